@@ design/fpa_pkg.sv @@
// Package for the Q24.8 fixed-point ALU: word types, command codes and
// the pipeline word handed from cell to cell. No dependencies.
package fpa_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int FRAC_MAX      = 16;
    // Dividend shift register: 32 magnitude bits plus FRAC_MAX+1 zero bits.
    localparam int DQ_W          = 33 + FRAC_MAX;

    localparam logic [31:0] MAX_RAW = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN_RAW = 32'h8000_0000;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_INC = 3'd4,
        CMD_DEC = 3'd5,
        CMD_MIN = 3'd6,
        CMD_MAX = 3'd7
    } t_cmd;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] result;
        logic               a_greater;
        logic               a_less;
        logic               a_equal;
        logic               overflow;
        logic               divide_by_zero;
    } t_out_word;

    typedef struct packed {
        logic            valid;
        t_cmd            cmd;
        logic            gt;
        logic            lt;
        logic            eq;
        logic            neg;
        logic            dz;
        logic            ovf;
        logic [31:0]     res;
        logic [63:0]     prod;
        logic [31:0]     dvs;
        logic [31:0]     rem;
        logic [DQ_W-1:0] dq;
    } t_pipe;

    // Saturates a 33-bit signed sum to 32 bits; the top bit returned is overflow.
    function automatic logic [32:0] sat33(input logic [32:0] v);
        logic [32:0] r;
        if (v[32] != v[31]) begin
            r = {1'b1, (v[32] ? MIN_RAW : MAX_RAW)};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    // Applies a sign to a magnitude with saturation; top bit is overflow.
    function automatic logic [32:0] sat_mag(input logic [63:0] m, input logic neg);
        logic [32:0] r;
        if (neg) begin
            if (m > 64'h0000_0000_8000_0000) begin
                r = {1'b1, MIN_RAW};
            end else begin
                r = {1'b0, 32'(-m[31:0])};
            end
        end else begin
            if (m > 64'h0000_0000_7FFF_FFFF) begin
                r = {1'b1, MAX_RAW};
            end else begin
                r = {1'b0, m[31:0]};
            end
        end
        return r;
    endfunction

endpackage

@@ design/fpa_pre.sv @@
// Entry stage of the ALU: compare flags, add/sub/inc/dec/min/max, the
// product magnitude and the divider setup. Depends on fpa_pkg.
module fpa_pre #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  fpa_pkg::t_in_word i_word,
    output fpa_pkg::t_pipe    o_pipe
);

    logic            r_valid;
    fpa_pkg::t_pipe  r_data;
    fpa_pkg::t_pipe  n_data;

    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [32:0] sa;
    logic [32:0] sb;
    logic [32:0] one;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [32:0] s;

    always_comb begin
        a   = i_word.operand_a;
        b   = i_word.operand_b;
        sa  = {a[31], a};
        sb  = {b[31], b};
        one = 33'(1) << FRAC_BITS;
        ma  = a[31] ? 32'(-a) : a;
        mb  = b[31] ? 32'(-b) : b;

        n_data       = '0;
        n_data.valid = i_valid;
        n_data.cmd   = fpa_pkg::t_cmd'(i_word.command);
        n_data.gt    = a > b;
        n_data.lt    = a < b;
        n_data.eq    = a == b;
        n_data.neg   = a[31] ^ b[31];
        n_data.dz    = 1'b0;
        n_data.prod  = 64'(ma) * 64'(mb);
        n_data.dvs   = mb;
        n_data.rem   = '0;
        // The doubled, scaled dividend is the magnitude followed by zeros.
        n_data.dq    = {ma, (fpa_pkg::DQ_W - 32)'(0)};

        s = '0;
        unique case (n_data.cmd)
            fpa_pkg::CMD_ADD: s = sa + sb;
            fpa_pkg::CMD_SUB: s = sa - sb;
            fpa_pkg::CMD_INC: s = sa + one;
            fpa_pkg::CMD_DEC: s = sa - one;
            default:          s = sa;
        endcase
        {n_data.ovf, n_data.res} = fpa_pkg::sat33(s);

        unique case (n_data.cmd)
            fpa_pkg::CMD_MIN: begin
                n_data.res = n_data.lt ? a : b;
                n_data.ovf = 1'b0;
            end
            fpa_pkg::CMD_MAX: begin
                n_data.res = n_data.gt ? a : b;
                n_data.ovf = 1'b0;
            end
            fpa_pkg::CMD_DIV: begin
                n_data.dz  = (b == 32'sd0);
                n_data.res = a[31] ? fpa_pkg::MIN_RAW : fpa_pkg::MAX_RAW;
                n_data.ovf = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_data.valid;
        end
        r_data <= n_data;
    end

    always_comb begin
        o_pipe       = r_data;
        o_pipe.valid = r_valid;
    end

endmodule

@@ design/fpa_div_cell.sv @@
// One restoring-division cell: takes one dividend bit, forms one quotient
// bit and passes the whole pipeline word on. Depends on fpa_pkg.
module fpa_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fpa_pkg::t_pipe i_pipe,
    output fpa_pkg::t_pipe o_pipe
);

    logic           r_valid;
    fpa_pkg::t_pipe r_data;
    fpa_pkg::t_pipe n_data;
    logic [32:0]    trial;
    logic           ge;

    always_comb begin
        trial = {i_pipe.rem, i_pipe.dq[fpa_pkg::DQ_W-1]};
        ge    = trial >= {1'b0, i_pipe.dvs};
        n_data     = i_pipe;
        n_data.rem = ge ? 32'(trial - {1'b0, i_pipe.dvs}) : trial[31:0];
        n_data.dq  = {i_pipe.dq[fpa_pkg::DQ_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_pipe.valid;
        end
        r_data <= n_data;
    end

    always_comb begin
        o_pipe       = r_data;
        o_pipe.valid = r_valid;
    end

endmodule

@@ design/fpa_post.sv @@
// Final stage: rounds and saturates multiply and divide results and
// assembles the result word. Combinational; depends on fpa_pkg.
module fpa_post #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  fpa_pkg::t_pipe    i_pipe,
    output fpa_pkg::t_out_word o_word
);

    logic [63:0] half;
    logic [63:0] m_mul;
    logic [63:0] m_div;
    logic [32:0] sm;
    logic [32:0] sd;

    always_comb begin
        half  = (64'(1) << FRAC_BITS) >> 1;
        m_mul = (i_pipe.prod + half) >> FRAC_BITS;
        // The cells produced floor(2n/d); adding one and halving rounds it.
        m_div = (64'(i_pipe.dq) + 64'(1)) >> 1;
        sm    = fpa_pkg::sat_mag(m_mul, i_pipe.neg);
        sd    = fpa_pkg::sat_mag(m_div, i_pipe.neg);

        o_word.a_greater      = i_pipe.gt;
        o_word.a_less         = i_pipe.lt;
        o_word.a_equal        = i_pipe.eq;
        o_word.divide_by_zero = i_pipe.dz;
        o_word.result         = i_pipe.res;
        o_word.overflow       = i_pipe.ovf;
        if (i_pipe.cmd == fpa_pkg::CMD_MUL) begin
            o_word.result   = sm[31:0];
            o_word.overflow = sm[32];
        end else if (i_pipe.cmd == fpa_pkg::CMD_DIV && !i_pipe.dz) begin
            o_word.result   = sd[31:0];
            o_word.overflow = sd[32];
        end
    end

endmodule

@@ design/fixed_point_alu_q24_8.sv @@
// Top level of the Q24.8 fixed-point ALU: entry stage, a chain of division
// cells and the output stage. Depends on fpa_pkg and the fpa_* modules.
//
//   channel   ports                  handshake
//   command   start, busy, i_word    taken when start is high and busy low
//   result    o_strobe, o_word       one word per strobe cycle, no stall
//
// Every word passes from start to strobe through one entry stage,
// 33 + FRAC_BITS division cells and one output register. A new word
// may be started in every cycle; busy stays low. Synchronous reset
// clears the valid bits along the chain.
module fixed_point_alu_q24_8 #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  fpa_pkg::t_in_word  i_word,
    output logic               o_strobe,
    output fpa_pkg::t_out_word o_word
);

    localparam int NCELL = 33 + FRAC_BITS;

    fpa_pkg::t_pipe     chain [NCELL+1];
    fpa_pkg::t_out_word post_word;
    logic               r_strobe;
    fpa_pkg::t_out_word r_word;

    assign busy = 1'b0;

    fpa_pre #(.FRAC_BITS(FRAC_BITS)) u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_word  (i_word),
        .o_pipe  (chain[0])
    );

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        fpa_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pipe  (chain[g]),
            .o_pipe  (chain[g+1])
        );
    end

    fpa_post #(.FRAC_BITS(FRAC_BITS)) u_post (
        .i_pipe (chain[NCELL]),
        .o_word (post_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= chain[NCELL].valid;
        end
        r_word <= post_word;
    end

    assign o_strobe = r_strobe;
    assign o_word   = r_word;

    a_dz_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_word.divide_by_zero) |-> !o_word.overflow)
        else $error("divide by zero also flagged overflow");

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_word.overflow) |->
        (o_word.result == fpa_pkg::MAX_RAW || o_word.result == fpa_pkg::MIN_RAW))
        else $error("overflow without a saturated result");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $onehot({o_word.a_greater, o_word.a_less, o_word.a_equal}))
        else $error("compare flags not one-hot");

endmodule
